// ===== src/gpe_pkg.sv =====
`default_nettype none

package gpe_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W = $clog2(MAX_VERTICES);
    localparam int COUNT_W = 7;

    typedef logic [MAX_VERTICES-1:0] row_t;
    typedef logic [VERT_W-1:0] vert_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_QUERY    = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_Q_PICK,
        ST_Q_MERGE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic  rd_en;
        vert_t rd_addr;
        logic  wr_en;
        vert_t wr_addr;
        row_t  wr_data;
        logic  clear;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== src/gpe_adj_mem.sv =====
`default_nettype none

module gpe_adj_mem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gpe_pkg::mem_req_t req,
    output gpe_pkg::row_t          rd_data
);
    import gpe_pkg::*;

    row_t mem [MAX_VERTICES];
    row_t rd_data_reg;
    logic rd_valid_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;

    // A row that was never written since reset or the last clear reads as empty.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (req.clear) begin
                row_valid_reg <= '0;
            end else if (req.wr_en) begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== src/gpe_search.sv =====
`default_nettype none

module gpe_search (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_cmd,
    input  wire gpe_pkg::vert_t    in_node_a,
    input  wire gpe_pkg::vert_t    in_node_b,
    input  wire gpe_pkg::count_t   vertex_count,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   res_found,
    output logic                   res_status,
    output gpe_pkg::mem_req_t      mem_req,
    input  wire gpe_pkg::row_t     mem_rd_data
);
    import gpe_pkg::*;

    function automatic vert_t lowest_set(input row_t bits);
        vert_t idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = vert_t'(i);
            end
        end
        return idx;
    endfunction

    state_t state_reg, state_next;
    vert_t  node_a_reg, node_b_reg;
    logic   found_reg, status_reg;
    row_t   visited_reg, pending_reg;

    cmd_t  cmd;
    logic  accept, bad_vertex;
    row_t  live, fresh, visited_new;
    vert_t cur;

    assign cmd        = cmd_t'(in_cmd);
    assign accept     = in_valid && in_ready;
    assign bad_vertex = ({1'b0, in_node_a} >= vertex_count)
                     || ({1'b0, in_node_b} >= vertex_count);
    assign cur         = lowest_set(pending_reg);
    assign fresh       = mem_rd_data & live & ~visited_reg;
    assign visited_new = visited_reg | fresh;

    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            live[v] = count_t'(v) < vertex_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (cmd == CMD_ADD_EDGE && !bad_vertex) begin
                        state_next = ST_ADD_RD_A;
                    end else if (cmd == CMD_QUERY && !bad_vertex
                                 && in_node_a != in_node_b) begin
                        state_next = ST_Q_PICK;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_ADD_RD_A: state_next = ST_ADD_WR_A;
            ST_ADD_WR_A: state_next = ST_ADD_RD_B;
            ST_ADD_RD_B: state_next = ST_ADD_WR_B;
            ST_ADD_WR_B: state_next = ST_RESP;
            ST_Q_PICK: begin
                state_next = (pending_reg == '0) ? ST_RESP : ST_Q_MERGE;
            end
            ST_Q_MERGE: begin
                state_next = visited_new[node_b_reg] ? ST_RESP : ST_Q_PICK;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        res_valid = 1'b0;
        mem_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                mem_req.clear = in_valid && cmd == CMD_CLEAR;
            end
            ST_ADD_RD_A: begin
                mem_req.rd_en = 1'b1;
                mem_req.rd_addr = node_a_reg;
            end
            ST_ADD_WR_A: begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = node_a_reg;
                mem_req.wr_data = mem_rd_data | (row_t'(1) << node_b_reg);
            end
            ST_ADD_RD_B: begin
                mem_req.rd_en = 1'b1;
                mem_req.rd_addr = node_b_reg;
            end
            ST_ADD_WR_B: begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = node_b_reg;
                mem_req.wr_data = mem_rd_data | (row_t'(1) << node_a_reg);
            end
            ST_Q_PICK: begin
                mem_req.rd_en = pending_reg != '0;
                mem_req.rd_addr = cur;
            end
            ST_Q_MERGE: begin
            end
            ST_RESP: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    node_a_reg  <= in_node_a;
                    node_b_reg  <= in_node_b;
                    status_reg  <= (cmd == CMD_ADD_EDGE || cmd == CMD_QUERY) && bad_vertex;
                    found_reg   <= cmd == CMD_QUERY && !bad_vertex
                                && in_node_a == in_node_b;
                    visited_reg <= row_t'(1) << in_node_a;
                    pending_reg <= row_t'(1) << in_node_a;
                end
            end
            ST_Q_PICK: begin
                pending_reg <= pending_reg & ~(row_t'(1) << cur);
            end
            ST_Q_MERGE: begin
                visited_reg <= visited_new;
                pending_reg <= pending_reg | fresh;
                found_reg   <= visited_new[node_b_reg];
            end
            default: begin
            end
        endcase
    end

    assign res_found  = found_reg;
    assign res_status = status_reg;

endmodule

`default_nettype wire

// ===== src/graph_path_exists_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// config    in         cfg_wr_en          cfg_wr_data (vertex_count)
// command   in         s_valid / s_ready  s_cmd, s_node_a, s_node_b
// result    out        m_valid / m_ready  m_path_found, m_status
//
// One command is worked on at a time; the next transfer is taken once the result
// sits in the output register, even while that result waits for m_ready.
// Clear, error and unused commands go straight to the result; an edge add reads and
// rewrites the row of node A, then the row of node B. A query alternates a pick and
// a merge step per adjacency row read (at most 64 rows) until it reaches the target
// or runs out of rows; a query that names one vertex twice goes straight to the result.
// While the output register holds a result, a new result waits until m_ready takes it.
// Reset empties the graph at once through per-row valid bits and sets vertex_count to 64.

module graph_path_exists_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire logic [5:0] s_node_a,
    input  wire logic [5:0] s_node_b,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_path_found,
    output logic            m_status
);
    import gpe_pkg::*;

    count_t   vertex_count_reg;
    mem_req_t mem_req;
    row_t     mem_rd_data;
    logic     res_valid, res_ready, res_found, res_status;
    logic     m_valid_reg, m_path_found_reg, m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= count_t'(MAX_VERTICES);
        end else if (cfg_wr_en) begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    gpe_adj_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    gpe_search u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_cmd       (s_cmd),
        .in_node_a    (s_node_a),
        .in_node_b    (s_node_b),
        .vertex_count (vertex_count_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_found    (res_found),
        .res_status   (res_status),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_path_found_reg <= res_found;
            m_status_reg     <= res_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_path_found = m_path_found_reg;
    assign m_status     = m_status_reg;

endmodule

`default_nettype wire

// ===== src/gpe_checker.sv =====
`default_nettype none

module gpe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_cmd,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_path_found,
    input wire logic       m_status
);
    import gpe_pkg::*;

    // A held result must not change while it waits.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_path_found) && $stable(m_status))
        else $error("result changed while stalled");

    // An error result never reports a path.
    a_err_no_path: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_path_found && m_status))
        else $error("path reported together with an error");

    // Only one command is in work at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while one is in work");

    // A clear transfer never yields an error or a path.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_CLEAR && !(m_valid && !m_ready)
        |=> ##1 m_valid && !m_status && !m_path_found)
        else $error("clear produced a wrong result");

    // Reset leaves no result pending and the command port open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind graph_path_exists_unit gpe_checker u_gpe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_path_found (m_path_found),
    .m_status     (m_status)
);

`default_nettype wire
